/* rtl/rdde_pkg.sv */
package rdde_pkg;

   localparam int SAMPLE_FRAC_BITS_DEF = 4;

   localparam int SENSOR_W    = 11;
   localparam int NUM_SENSORS = 5;
   localparam int DIST_W      = 14;
   localparam int CFG_W       = 14;
   localparam int CSR_IDX_W   = 1;
   localparam int ROUND_SHIFT = 8;   // Q8 fraction of the distance

   localparam int REQ_DATA_W = ((NUM_SENSORS * SENSOR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DIST_W + 2 + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_NORMAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CIRCLE = 1'b1;

   localparam logic [CFG_W-1:0] MAX_DIST_RESET = 14'd8978;

   // cubic coefficients, scaled by 1e8
   localparam longint C3     = 64'sd6075;
   localparam longint C2     = 64'sd1111000;
   localparam longint C1     = 64'sd85000000;
   localparam longint C0     = 64'sd3507000000;
   localparam longint CSCALE = 64'sd100000000;

   typedef struct packed {
      logic circle;
      logic late;
   } mode_flags_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef struct packed {
      logic              below_min;
      logic [DIST_W-1:0] quot;
   } div_result_type;

   // largest value the cubic argument can take
   function automatic longint x_max(input int f);
      longint t;
      t = longint'(100) << f;
      return (t > longint'((1 << SENSOR_W) - 1)) ? t : longint'((1 << SENSOR_W) - 1);
   endfunction

   function automatic int x_width(input int f);
      return $clog2(x_max(f) + 1);
   endfunction

   // signed width that holds every Horner partial result
   function automatic int acc_width(input int f);
      longint xm;
      longint one;
      longint b;
      xm  = x_max(f);
      one = longint'(1) << f;
      b   = C3 * xm * xm * xm + C2 * xm * xm * one + C1 * xm * one * one
          + C0 * one * one * one;
      return $clog2(b + 1) + 1;
   endfunction

   function automatic longint den_value(input int f);
      return CSCALE << (3 * f);
   endfunction

   function automatic int den_width(input int f);
      return $clog2(den_value(f) + 1);
   endfunction

   // constant added after each multiply by x
   function automatic longint horner_addend(input int f, input int stage);
      longint one;
      longint r;
      one = longint'(1) << f;
      unique case (stage)
         0: r = C2 * one;
         1: r = -(C1 * one * one);
         default: r = C0 * one * one * one;
      endcase
      return r;
   endfunction

endpackage

/* rtl/rdde_mode.sv */
module rdde_mode #(
   parameter int SAMPLE_FRAC_BITS = rdde_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic [rdde_pkg::SENSOR_W-1:0]          s0,
   input  logic [rdde_pkg::SENSOR_W-1:0]          s1,
   input  logic [rdde_pkg::SENSOR_W-1:0]          s2,
   input  logic [rdde_pkg::SENSOR_W-1:0]          s3,
   input  logic [rdde_pkg::SENSOR_W-1:0]          s4,
   output rdde_pkg::mode_flags_type               flags,
   output logic [rdde_pkg::x_width(SAMPLE_FRAC_BITS)-1:0] x_next
);

   localparam int XW = rdde_pkg::x_width(SAMPLE_FRAC_BITS);
   localparam int TW = XW + 2;
   localparam int SW = rdde_pkg::SENSOR_W;

   localparam logic [TW-1:0] THR_5   = TW'(5 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_25  = TW'(25 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_30  = TW'(30 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_50  = TW'(50 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_60  = TW'(60 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_70  = TW'(70 << SAMPLE_FRAC_BITS);
   localparam logic [TW-1:0] THR_100 = TW'(100 << SAMPLE_FRAC_BITS);

   rdde_pkg::mode_flags_type flags_ff, flags_in;

   logic [TW-1:0]        w0, w1, w2, w3, w4;
   logic signed [SW+1:0] side;
   logic [SW:0]          mag;
   logic                 entry;
   logic [TW-1:0]        x_sum, x_dbl, x_sel;

   assign w0 = TW'(s0);
   assign w1 = TW'(s1);
   assign w2 = TW'(s2);
   assign w3 = TW'(s3);
   assign w4 = TW'(s4);

   always_comb begin
      side = $signed({2'b00, s4}) + $signed({2'b00, s3})
           - $signed({2'b00, s0}) - $signed({2'b00, s1});
      mag  = side[SW+1] ? (SW+1)'(-side) : (SW+1)'(side);
   end

   // halved imbalance below 15 is the same as magnitude below 30 units
   assign entry = (w2 > THR_25) && (w2 < THR_50) && (TW'(mag) < THR_30)
                && (w0 <= THR_30) && (w4 <= THR_30)
                && (w0 >= THR_5) && (w4 >= THR_5);

   always_comb begin
      flags_in = flags_ff;
      if (entry) begin
         flags_in.circle = 1'b1;
      end else begin
         if ((w2 > THR_60) && flags_ff.circle) begin
            flags_in.late = 1'b1;
         end
         if (((w1 > THR_70) || (w3 > THR_70)) && flags_ff.circle) begin
            flags_in.circle = 1'b0;
            flags_in.late   = 1'b0;
         end
      end
   end

   always_comb begin
      x_sum = w2 + (flags_in.late ? THR_5 : '0);
      x_dbl = {x_sum[TW-2:0], 1'b0};
      if (flags_in.circle) begin
         x_sel = (x_dbl > THR_100) ? THR_100 : x_dbl;
      end else begin
         x_sel = w2;
      end
   end

   assign x_next = x_sel[XW-1:0];
   assign flags  = flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (load) begin
         flags_ff <= flags_in;
      end
   end

endmodule

/* rtl/rdde_cubic.sv */
module rdde_cubic #(
   parameter int SAMPLE_FRAC_BITS = rdde_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   input  logic [rdde_pkg::x_width(SAMPLE_FRAC_BITS)-1:0]   x,
   output rdde_pkg::unit_status_type                        status,
   output logic signed [rdde_pkg::acc_width(SAMPLE_FRAC_BITS)-1:0] d
);

   localparam int XW = rdde_pkg::x_width(SAMPLE_FRAC_BITS);
   localparam int DW = rdde_pkg::acc_width(SAMPLE_FRAC_BITS);
   localparam int CW = (XW > 1) ? $clog2(XW) : 1;

   localparam logic signed [DW-1:0] A_INIT = DW'(-rdde_pkg::C3);
   localparam logic signed [DW-1:0] K0 = DW'(rdde_pkg::horner_addend(SAMPLE_FRAC_BITS, 0));
   localparam logic signed [DW-1:0] K1 = DW'(rdde_pkg::horner_addend(SAMPLE_FRAC_BITS, 1));
   localparam logic signed [DW-1:0] K2 = DW'(rdde_pkg::horner_addend(SAMPLE_FRAC_BITS, 2));

   localparam logic [CW-1:0] CNT_LAST   = CW'(XW - 1);
   localparam logic [1:0]    STAGE_LAST = 2'd2;

   localparam logic PH_MUL = 1'b0;
   localparam logic PH_ADD = 1'b1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 phase_ff, phase_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           stage_ff, stage_in;
   logic signed [DW-1:0] a_ff, a_in;
   logic signed [DW-1:0] p_ff, p_in;
   logic [XW-1:0]        x_ff, x_in;

   logic signed [DW-1:0] addend, p_mul, k_sel;

   always_comb begin
      addend = x_ff[XW-1] ? a_ff : '0;
      p_mul  = {p_ff[DW-2:0], 1'b0} + addend;
      unique case (stage_ff)
         2'd0:    k_sel = K0;
         2'd1:    k_sel = K1;
         default: k_sel = K2;
      endcase
   end

   // Horner: acc = acc*x + k, each multiply one bit of x per cycle, MSB first
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      a_in     = a_ff;
      p_in     = p_ff;
      x_in     = x_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_MUL;
         cnt_in   = '0;
         stage_in = '0;
         a_in     = A_INIT;
         p_in     = '0;
         x_in     = x;
      end else if (busy_ff) begin
         unique case (phase_ff)
            PH_MUL: begin
               p_in   = p_mul;
               x_in   = {x_ff[XW-2:0], x_ff[XW-1]};
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CNT_LAST) begin
                  phase_in = PH_ADD;
               end
            end
            PH_ADD: begin
               a_in     = p_ff + k_sel;
               p_in     = '0;
               cnt_in   = '0;
               phase_in = PH_MUL;
               if (stage_ff == STAGE_LAST) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  stage_in = stage_ff + 2'd1;
               end
            end
            default: phase_in = PH_MUL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_MUL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      stage_ff <= stage_in;
      a_ff     <= a_in;
      p_ff     <= p_in;
      x_ff     <= x_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign d           = a_ff;

endmodule

/* rtl/rdde_div.sv */
module rdde_div #(
   parameter int SAMPLE_FRAC_BITS = rdde_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    start,
   input  logic signed [rdde_pkg::acc_width(SAMPLE_FRAC_BITS)-1:0] d,
   output rdde_pkg::unit_status_type                               status,
   output rdde_pkg::div_result_type                                result
);

   localparam int     DW   = rdde_pkg::acc_width(SAMPLE_FRAC_BITS);
   localparam longint DEN  = rdde_pkg::den_value(SAMPLE_FRAC_BITS);
   localparam int     DENW = rdde_pkg::den_width(SAMPLE_FRAC_BITS);
   localparam int     TW   = DENW + 1;
   localparam int     QW   = rdde_pkg::DIST_W;
   localparam int     NW   = DW + rdde_pkg::ROUND_SHIFT;
   localparam int     QCW  = $clog2(QW);

   localparam logic [TW-1:0]        DEN_V    = TW'(DEN);
   localparam logic [NW-1:0]        HALF_DEN = NW'(DEN / 2);
   localparam logic signed [DW-1:0] TWO_DEN  = DW'(2 * DEN);
   localparam logic [QCW-1:0]       CNT_LAST = QCW'(QW - 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            below_ff, below_in;
   logic [QCW-1:0]  cnt_ff, cnt_in;
   logic [DENW-1:0] rem_ff, rem_in;
   logic [QW-1:0]   low_ff, low_in;   // dividend bits out at the top, quotient in at the bottom

   logic [NW-1:0]   n_full;
   logic [TW-1:0]   trial;
   logic            ge;

   // rounded Q8: floor((256*d + den/2) / den)
   assign n_full = {1'b0, d[DW-2:0], {rdde_pkg::ROUND_SHIFT{1'b0}}} + HALF_DEN;
   assign trial  = {rem_ff, low_ff[QW-1]};
   assign ge     = (trial >= DEN_V);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      below_in = below_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      if (start) begin
         busy_in  = 1'b1;
         below_in = (d < TWO_DEN);
         cnt_in   = '0;
         rem_in   = n_full[QW +: DENW];
         low_in   = n_full[QW-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? DENW'(trial - DEN_V) : trial[DENW-1:0];
         low_in = {low_ff[QW-2:0], ge};
         cnt_in = cnt_ff + QCW'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      below_ff <= below_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
   end

   assign status.busy      = busy_ff;
   assign status.done      = done_ff;
   assign result.below_min = below_ff;
   assign result.quot      = low_ff;

endmodule

/* rtl/roundabout_detect_distance_estimate_unit.sv */
// Channel  Dir  Ports          Payload
// req      in   req_tdata[56]  five 11-bit sensor readings, far left in the lowest bits
// rsp      out  rsp_tdata[16]  distance[13:0], in_circle[14], indicator_off[15]
// csr      in   csr_wen/index  index 0 normal ceiling, 1 circle ceiling, 14-bit data
//
// One item at a time: the input opens again only after the item has passed the
// bit-serial Horner multiplier and the 14-step constant divider and its result
// has been loaded into the output register.
// A finished result waits in the output register; the next item is taken meanwhile.
// If that register is still full when the next result is ready, the input stays closed.
// Synchronous reset clears both flags and loads the ceilings with 8978.
module roundabout_detect_distance_estimate_unit #(
   parameter int SAMPLE_FRAC_BITS = rdde_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // far_left[10:0], left[21:11], center[32:22], right[43:33], far_right[54:44], 0
   input  logic [rdde_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // line_distance[13:0], in_circle[14], indicator_off[15]
   output logic [rdde_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [rdde_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rdde_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int SW = rdde_pkg::SENSOR_W;
   localparam int XW = rdde_pkg::x_width(SAMPLE_FRAC_BITS);
   localparam int DW = rdde_pkg::acc_width(SAMPLE_FRAC_BITS);
   localparam int LW = rdde_pkg::DIST_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CUBIC = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [rdde_pkg::CFG_W-1:0]   max_normal_ff, max_circle_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                dist_ff;
   logic                         circle_out_ff;

   logic                         req_accept, out_free, load_out;
   rdde_pkg::mode_flags_type     flags;
   logic [XW-1:0]                x_next;
   rdde_pkg::unit_status_type    cubic_status, div_status;
   logic signed [DW-1:0]         cubic_d;
   rdde_pkg::div_result_type     div_result;
   logic [LW-1:0]                cap, dist_sel;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rdde_mode #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_mode (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .s0     (req_tdata[0*SW +: SW]),
      .s1     (req_tdata[1*SW +: SW]),
      .s2     (req_tdata[2*SW +: SW]),
      .s3     (req_tdata[3*SW +: SW]),
      .s4     (req_tdata[4*SW +: SW]),
      .flags  (flags),
      .x_next (x_next)
   );

   rdde_cubic #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_cubic (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .x      (x_next),
      .status (cubic_status),
      .d      (cubic_d)
   );

   rdde_div #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cubic_status.done),
      .d      (cubic_d),
      .status (div_status),
      .result (div_result)
   );

   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CUBIC;
            end
         end
         ST_CUBIC: begin
            if (cubic_status.done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               load_out = out_free;
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // flags only move at accept, so they still belong to this item
   always_comb begin
      cap      = flags.circle ? max_circle_ff : max_normal_ff;
      dist_sel = div_result.below_min ? '0 : div_result.quot;
      if (dist_sel > cap) begin
         dist_sel = cap;
      end
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_normal_ff <= rdde_pkg::MAX_DIST_RESET;
         max_circle_ff <= rdde_pkg::MAX_DIST_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               rdde_pkg::REG_MAX_NORMAL: max_normal_ff <= csr_wdata;
               rdde_pkg::REG_MAX_CIRCLE: max_circle_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         dist_ff       <= dist_sel;
         circle_out_ff <= flags.circle;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {~circle_out_ff, circle_out_ff, dist_ff};

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (cubic_status.busy && !req_tready))
      else $error("item accepted but cubic engine not running");

   a_cubic_done_state: assert property (@(posedge clock) disable iff (reset)
      cubic_status.done |-> (state_ff == ST_CUBIC && !div_status.busy))
      else $error("cubic result arrived outside its state");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result held back while output register empty");

endmodule
